// ===== design/icm_pkg.sv =====
// Shared types, widths and reset constants for the incremental conductance tracker.
// Depends on nothing; every other design file refers to it by scoped names.
package icm_pkg;

    localparam int CUR_W      = 16;
    localparam int VOLT_W     = 16;
    localparam int CNT_W      = 10;
    localparam int STEP_W     = 8;
    localparam int BAND_W     = 10;
    localparam int TOL_W      = 4;
    localparam int OFFS_W     = 11;
    localparam int GAIN_W     = 11;
    localparam int GAIN_FRAC  = 10;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 26;
    localparam int DIFF_W     = 17;
    localparam int CAL_W      = 18;
    localparam int MUL_A_W    = 22;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 40;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DUTY_MIN   = 10;

    localparam logic [CNT_W-1:0]       SAMPLE_COUNT_RST    = 10'd1000;
    localparam logic [STEP_W-1:0]      DUTY_STEP_RST       = 8'd20;
    localparam logic [BAND_W-1:0]      VOLTAGE_BAND_RST    = 10'd10;
    localparam logic [BAND_W-1:0]      CURRENT_BAND_RST    = 10'd20;
    localparam logic [TOL_W-1:0]       SLOPE_TOL_RST       = 4'd2;
    localparam logic [VOLT_W-1:0]      MAX_LOW_VOLTAGE_RST = 16'd15000;
    localparam logic [OFFS_W-1:0]      LOW_OFFSET_RST      = 11'd36;
    localparam logic [GAIN_W-1:0]      HIGH_GAIN_RST       = 11'd1004;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT    = 3'd0,
        CFG_DUTY_STEP       = 3'd1,
        CFG_VOLTAGE_BAND    = 3'd2,
        CFG_CURRENT_BAND    = 3'd3,
        CFG_SLOPE_TOL       = 3'd4,
        CFG_MAX_LOW_VOLTAGE = 3'd5,
        CFG_LOW_OFFSET      = 3'd6,
        CFG_HIGH_GAIN       = 3'd7
    } cfg_idx_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_HOLD  = 2'd0,
        DIR_RAISE = 2'd1,
        DIR_LOWER = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SEL_LOW_VOLT  = 2'd0,
        SEL_HIGH_VOLT = 2'd1,
        SEL_LOW_CUR   = 2'd2,
        SEL_HIGH_CUR  = 2'd3
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CLASSIFY,
        ST_MUL_TV,
        ST_MUL_LHS,
        ST_MUL_UP,
        ST_MUL_DN,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/icm_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned sum by tick count.
// Depends on icm_pkg for widths and the request and response structs.
module icm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  icm_pkg::div_req_t req,
    output icm_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [icm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [icm_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [icm_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [icm_pkg::CNT_W-1:0]     dvs_reg, dvs_next;
    logic [icm_pkg::CNT_W:0]       trial;
    logic [icm_pkg::CNT_W:0]       diff;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[icm_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = busy_reg && (cnt_reg == '0);
        if (!busy_reg && req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = icm_pkg::DIV_CNT_W'(icm_pkg::DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[icm_pkg::CNT_W-1:0] : trial[icm_pkg::CNT_W-1:0];
            quo_next = {quo_reg[icm_pkg::SUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/icm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on icm_pkg for operand and product widths.
module icm_mul (
    input  logic                               clk,
    input  logic signed [icm_pkg::MUL_A_W-1:0] a,
    input  logic signed [icm_pkg::MUL_B_W-1:0] b,
    output logic signed [icm_pkg::PROD_W-1:0]  product
);

    logic signed [icm_pkg::PROD_W-1:0] prod_reg, prod_next;

    assign prod_next = icm_pkg::PROD_W'(a) * icm_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

// ===== design/incremental_conductance_mppt_top.sv =====
// Incremental conductance tracker: calibration, window sums, averaging and duty decision.
// Depends on icm_pkg, icm_div and icm_mul.
// A tick that does not close the window passes through calibration and returns to idle,
// where in_ready is high again. A window-closing tick runs the 26-step divider once for
// each of the four averages and then the duty decision before out_valid is raised.
// Reset: window, sums and history clear, duty returns to half scale, registers to defaults.
module incremental_conductance_mppt_top #(
    parameter int DUTY_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [icm_pkg::CUR_W-1:0]      low_current,
    input  logic signed [icm_pkg::CUR_W-1:0]      high_current,
    input  logic [icm_pkg::VOLT_W-1:0]            low_voltage_raw,
    input  logic [icm_pkg::VOLT_W-1:0]            high_voltage_raw,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [DUTY_BITS-1:0]                  duty_cycle,
    output logic [icm_pkg::DIR_W-1:0]             step_direction,
    output logic [icm_pkg::VOLT_W-1:0]            avg_low_voltage,
    output logic signed [icm_pkg::CUR_W-1:0]      avg_low_current,
    output logic [icm_pkg::VOLT_W-1:0]            avg_high_voltage,
    output logic signed [icm_pkg::CUR_W-1:0]      avg_high_current,
    output logic                                  overvoltage,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [icm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [icm_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DW = DUTY_BITS + 2;
    localparam logic signed [DW-1:0] DUTY_MIN_S = DW'(icm_pkg::DUTY_MIN);
    localparam logic signed [DW-1:0] DUTY_MAX_S = DW'((1 << DUTY_BITS) - 1);
    localparam logic [DUTY_BITS-1:0] DUTY_RST   = DUTY_BITS'(1 << (DUTY_BITS - 1));

    // configuration registers
    logic [icm_pkg::CNT_W-1:0]         sample_count_reg;
    logic [icm_pkg::STEP_W-1:0]        duty_step_reg;
    logic [icm_pkg::BAND_W-1:0]        voltage_band_reg;
    logic [icm_pkg::BAND_W-1:0]        current_band_reg;
    logic [icm_pkg::TOL_W-1:0]         slope_tol_reg;
    logic [icm_pkg::VOLT_W-1:0]        max_low_voltage_reg;
    logic signed [icm_pkg::OFFS_W-1:0] low_offset_reg;
    logic [icm_pkg::GAIN_W-1:0]        high_gain_reg;

    icm_pkg::state_t                   state_reg, state_next;
    icm_pkg::div_sel_t                 sel_reg, sel_next;
    icm_pkg::dir_t                     dir_reg, dir_next;

    logic signed [icm_pkg::CUR_W-1:0]  in_il_reg, in_il_next;
    logic signed [icm_pkg::CUR_W-1:0]  in_ih_reg, in_ih_next;
    logic [icm_pkg::VOLT_W-1:0]        in_vl_reg, in_vl_next;

    logic signed [icm_pkg::SUM_W-1:0]  lc_sum_reg, lc_sum_next;
    logic signed [icm_pkg::SUM_W-1:0]  hc_sum_reg, hc_sum_next;
    logic [icm_pkg::SUM_W-1:0]         lv_sum_reg, lv_sum_next;
    logic [icm_pkg::SUM_W-1:0]         hv_sum_reg, hv_sum_next;
    logic [icm_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [icm_pkg::CNT_W-1:0]         n_reg, n_next;

    logic [icm_pkg::VOLT_W-1:0]        avg_lv_reg, avg_lv_next;
    logic [icm_pkg::VOLT_W-1:0]        avg_hv_reg, avg_hv_next;
    logic signed [icm_pkg::CUR_W-1:0]  avg_li_reg, avg_li_next;
    logic signed [icm_pkg::CUR_W-1:0]  avg_hi_reg, avg_hi_next;
    logic [icm_pkg::VOLT_W-1:0]        prev_lv_reg, prev_lv_next;
    logic signed [icm_pkg::CUR_W-1:0]  prev_li_reg, prev_li_next;
    logic [DUTY_BITS-1:0]              duty_reg, duty_next;
    logic                              ov_reg, ov_next;

    logic signed [icm_pkg::MUL_A_W-1:0] tv_reg, tv_next;
    logic signed [icm_pkg::PROD_W-1:0]  lhs_reg, lhs_next;
    logic signed [icm_pkg::PROD_W-1:0]  up_reg, up_next;

    logic                              out_valid_reg, out_valid_next;
    logic [DUTY_BITS-1:0]              out_duty_reg, out_duty_next;
    icm_pkg::dir_t                     out_dir_reg, out_dir_next;
    logic [icm_pkg::VOLT_W-1:0]        out_lv_reg, out_lv_next;
    logic signed [icm_pkg::CUR_W-1:0]  out_li_reg, out_li_next;
    logic [icm_pkg::VOLT_W-1:0]        out_hv_reg, out_hv_next;
    logic signed [icm_pkg::CUR_W-1:0]  out_hi_reg, out_hi_next;
    logic                              out_ov_reg, out_ov_next;

    icm_pkg::div_req_t                 div_req;
    icm_pkg::div_rsp_t                 div_rsp;
    logic signed [icm_pkg::MUL_A_W-1:0] mul_a;
    logic signed [icm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [icm_pkg::PROD_W-1:0]  product;

    logic                              in_fire;
    logic                              out_free;
    logic signed [icm_pkg::CAL_W-1:0]  vl_wide;
    logic [icm_pkg::VOLT_W-1:0]        vl_sat;
    logic [icm_pkg::VOLT_W-1:0]        vh_sat;
    logic [icm_pkg::CNT_W-1:0]         cnt_plus;
    logic                              window_done;
    logic [icm_pkg::SUM_W-1:0]         lc_abs;
    logic [icm_pkg::SUM_W-1:0]         hc_abs;
    logic                              div_neg;
    logic [icm_pkg::DIFF_W-1:0]        q_mag;
    logic [icm_pkg::DIFF_W-1:0]        q_signed;
    logic signed [icm_pkg::DIFF_W-1:0] dv;
    logic signed [icm_pkg::DIFF_W-1:0] di;
    logic signed [icm_pkg::DIFF_W-1:0] vb_s;
    logic signed [icm_pkg::DIFF_W-1:0] cb_s;
    logic                              steady;
    logic signed [icm_pkg::MUL_A_W-1:0] li_ext;
    logic                              raise;
    logic                              lower;
    logic signed [DW-1:0]              duty_ext;
    logic signed [DW-1:0]              step_ext;
    logic signed [DW-1:0]              duty_sum;
    logic [DUTY_BITS-1:0]              duty_new;

    icm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    icm_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign in_ready  = (state_reg == icm_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // calibration
    assign vl_wide = signed'({2'b00, in_vl_reg})
                   + {{(icm_pkg::CAL_W - icm_pkg::OFFS_W){low_offset_reg[icm_pkg::OFFS_W-1]}},
                      low_offset_reg};
    always_comb
    begin
        priority if (vl_wide[icm_pkg::CAL_W-1])
        begin
            vl_sat = '0;
        end
        else if (vl_wide[icm_pkg::VOLT_W])
        begin
            vl_sat = '1;
        end
        else
        begin
            vl_sat = vl_wide[icm_pkg::VOLT_W-1:0];
        end
    end
    assign vh_sat = (product[icm_pkg::PROD_W-1:icm_pkg::VOLT_W+icm_pkg::GAIN_FRAC] != '0)
                  ? '1 : product[icm_pkg::VOLT_W+icm_pkg::GAIN_FRAC-1:icm_pkg::GAIN_FRAC];

    assign cnt_plus    = count_reg + 1'b1;
    assign window_done = cnt_plus >= sample_count_reg;

    // averaging
    assign lc_abs = lc_sum_reg[icm_pkg::SUM_W-1] ? (~lc_sum_reg + 1'b1) : lc_sum_reg;
    assign hc_abs = hc_sum_reg[icm_pkg::SUM_W-1] ? (~hc_sum_reg + 1'b1) : hc_sum_reg;

    always_comb
    begin
        unique case (sel_reg)
            icm_pkg::SEL_LOW_VOLT:
            begin
                div_req.dividend = lv_sum_reg;
                div_neg          = 1'b0;
            end
            icm_pkg::SEL_HIGH_VOLT:
            begin
                div_req.dividend = hv_sum_reg;
                div_neg          = 1'b0;
            end
            icm_pkg::SEL_LOW_CUR:
            begin
                div_req.dividend = lc_abs;
                div_neg          = lc_sum_reg[icm_pkg::SUM_W-1];
            end
            icm_pkg::SEL_HIGH_CUR:
            begin
                div_req.dividend = hc_abs;
                div_neg          = hc_sum_reg[icm_pkg::SUM_W-1];
            end
        endcase
    end
    assign div_req.divisor = n_reg;
    assign div_req.start   = (state_reg == icm_pkg::ST_DIV_START);

    assign q_mag    = div_rsp.quotient[icm_pkg::DIFF_W-1:0];
    assign q_signed = div_neg ? (~q_mag + 1'b1) : q_mag;

    // decision terms
    assign dv     = signed'({1'b0, avg_lv_reg}) - signed'({1'b0, prev_lv_reg});
    assign di     = {avg_li_reg[icm_pkg::CUR_W-1], avg_li_reg}
                  - {prev_li_reg[icm_pkg::CUR_W-1], prev_li_reg};
    assign vb_s   = signed'({{(icm_pkg::DIFF_W - icm_pkg::BAND_W){1'b0}}, voltage_band_reg});
    assign cb_s   = signed'({{(icm_pkg::DIFF_W - icm_pkg::BAND_W){1'b0}}, current_band_reg});
    assign steady = (dv == '0) || ((dv > -vb_s) && (dv < vb_s));
    assign li_ext = {{(icm_pkg::MUL_A_W - icm_pkg::CUR_W){avg_li_reg[icm_pkg::CUR_W-1]}},
                     avg_li_reg};
    assign raise  = (dv > 0) ? (lhs_reg > up_reg) : (lhs_reg < up_reg);
    assign lower  = (dv > 0) ? (lhs_reg < product) : (lhs_reg > product);

    always_comb
    begin
        unique case (state_reg)
            icm_pkg::ST_MUL_TV:
            begin
                mul_a = signed'({{(icm_pkg::MUL_A_W - icm_pkg::TOL_W){1'b0}}, slope_tol_reg});
                mul_b = signed'({2'b00, avg_lv_reg});
            end
            icm_pkg::ST_MUL_LHS:
            begin
                mul_a = {{(icm_pkg::MUL_A_W - icm_pkg::DIFF_W){di[icm_pkg::DIFF_W-1]}}, di};
                mul_b = signed'({2'b00, avg_lv_reg});
            end
            icm_pkg::ST_MUL_UP:
            begin
                mul_a = tv_reg - li_ext;
                mul_b = {dv[icm_pkg::DIFF_W-1], dv};
            end
            icm_pkg::ST_MUL_DN:
            begin
                mul_a = -(li_ext + tv_reg);
                mul_b = {dv[icm_pkg::DIFF_W-1], dv};
            end
            default:
            begin
                mul_a = signed'({{(icm_pkg::MUL_A_W - icm_pkg::VOLT_W){1'b0}},
                                 high_voltage_raw});
                mul_b = signed'({{(icm_pkg::MUL_B_W - icm_pkg::GAIN_W){1'b0}}, high_gain_reg});
            end
        endcase
    end

    // duty update
    assign duty_ext = signed'({2'b00, duty_reg});
    assign step_ext = signed'(DW'(duty_step_reg));
    always_comb
    begin
        unique case (dir_reg)
            icm_pkg::DIR_RAISE: duty_sum = duty_ext + step_ext;
            icm_pkg::DIR_LOWER: duty_sum = duty_ext - step_ext;
            default:            duty_sum = duty_ext;
        endcase
        priority if (duty_sum < DUTY_MIN_S)
        begin
            duty_new = DUTY_MIN_S[DUTY_BITS-1:0];
        end
        else if (duty_sum > DUTY_MAX_S)
        begin
            duty_new = DUTY_MAX_S[DUTY_BITS-1:0];
        end
        else
        begin
            duty_new = duty_sum[DUTY_BITS-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            icm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = icm_pkg::ST_CAL;
                end
            end
            icm_pkg::ST_CAL:
            begin
                state_next = window_done ? icm_pkg::ST_DIV_START : icm_pkg::ST_IDLE;
            end
            icm_pkg::ST_DIV_START:
            begin
                state_next = icm_pkg::ST_DIV_WAIT;
            end
            icm_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (sel_reg == icm_pkg::SEL_HIGH_CUR) ? icm_pkg::ST_CLASSIFY
                                                                     : icm_pkg::ST_DIV_START;
                end
            end
            icm_pkg::ST_CLASSIFY:
            begin
                state_next = (steady || (avg_lv_reg == '0)) ? icm_pkg::ST_APPLY
                                                             : icm_pkg::ST_MUL_TV;
            end
            icm_pkg::ST_MUL_TV:  state_next = icm_pkg::ST_MUL_LHS;
            icm_pkg::ST_MUL_LHS: state_next = icm_pkg::ST_MUL_UP;
            icm_pkg::ST_MUL_UP:  state_next = icm_pkg::ST_MUL_DN;
            icm_pkg::ST_MUL_DN:  state_next = icm_pkg::ST_COMPARE;
            icm_pkg::ST_COMPARE: state_next = icm_pkg::ST_APPLY;
            icm_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = icm_pkg::ST_IDLE;
                end
            end
            default: state_next = icm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sel_next     = sel_reg;
        dir_next     = dir_reg;
        in_il_next   = in_il_reg;
        in_ih_next   = in_ih_reg;
        in_vl_next   = in_vl_reg;
        lc_sum_next  = lc_sum_reg;
        hc_sum_next  = hc_sum_reg;
        lv_sum_next  = lv_sum_reg;
        hv_sum_next  = hv_sum_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        avg_lv_next  = avg_lv_reg;
        avg_hv_next  = avg_hv_reg;
        avg_li_next  = avg_li_reg;
        avg_hi_next  = avg_hi_reg;
        prev_lv_next = prev_lv_reg;
        prev_li_next = prev_li_reg;
        duty_next    = duty_reg;
        ov_next      = ov_reg;
        tv_next      = tv_reg;
        lhs_next     = lhs_reg;
        up_next      = up_reg;
        out_duty_next = out_duty_reg;
        out_dir_next  = out_dir_reg;
        out_lv_next   = out_lv_reg;
        out_li_next   = out_li_reg;
        out_hv_next   = out_hv_reg;
        out_hi_next   = out_hi_reg;
        out_ov_next   = out_ov_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            icm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    in_il_next = low_current;
                    in_ih_next = high_current;
                    in_vl_next = low_voltage_raw;
                end
            end
            icm_pkg::ST_CAL:
            begin
                lc_sum_next = lc_sum_reg
                            + {{(icm_pkg::SUM_W - icm_pkg::CUR_W){in_il_reg[icm_pkg::CUR_W-1]}},
                               in_il_reg};
                hc_sum_next = hc_sum_reg
                            + {{(icm_pkg::SUM_W - icm_pkg::CUR_W){in_ih_reg[icm_pkg::CUR_W-1]}},
                               in_ih_reg};
                lv_sum_next = lv_sum_reg + icm_pkg::SUM_W'(vl_sat);
                hv_sum_next = hv_sum_reg + icm_pkg::SUM_W'(vh_sat);
                n_next      = cnt_plus;
                sel_next    = icm_pkg::SEL_LOW_VOLT;
                if (!window_done)
                begin
                    count_next = cnt_plus;
                end
            end
            icm_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (sel_reg)
                        icm_pkg::SEL_LOW_VOLT:
                            avg_lv_next = div_rsp.quotient[icm_pkg::VOLT_W-1:0];
                        icm_pkg::SEL_HIGH_VOLT:
                            avg_hv_next = div_rsp.quotient[icm_pkg::VOLT_W-1:0];
                        icm_pkg::SEL_LOW_CUR:
                            avg_li_next = signed'(q_signed[icm_pkg::CUR_W-1:0]);
                        icm_pkg::SEL_HIGH_CUR:
                            avg_hi_next = signed'(q_signed[icm_pkg::CUR_W-1:0]);
                    endcase
                    sel_next = icm_pkg::div_sel_t'(sel_reg + 2'd1);
                end
            end
            icm_pkg::ST_CLASSIFY:
            begin
                if (avg_lv_reg > max_low_voltage_reg)
                begin
                    ov_next = 1'b1;
                end
                dir_next = icm_pkg::DIR_HOLD;
                if (steady)
                begin
                    priority if (di > cb_s)
                    begin
                        dir_next = icm_pkg::DIR_RAISE;
                    end
                    else if (di < -cb_s)
                    begin
                        dir_next = icm_pkg::DIR_LOWER;
                    end
                    else
                    begin
                        dir_next = icm_pkg::DIR_HOLD;
                    end
                end
            end
            icm_pkg::ST_MUL_LHS:
            begin
                tv_next = product[icm_pkg::MUL_A_W-1:0];
            end
            icm_pkg::ST_MUL_UP:
            begin
                lhs_next = product;
            end
            icm_pkg::ST_MUL_DN:
            begin
                up_next = product;
            end
            icm_pkg::ST_COMPARE:
            begin
                priority if (raise)
                begin
                    dir_next = icm_pkg::DIR_RAISE;
                end
                else if (lower)
                begin
                    dir_next = icm_pkg::DIR_LOWER;
                end
                else
                begin
                    dir_next = icm_pkg::DIR_HOLD;
                end
            end
            icm_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    duty_next      = duty_new;
                    prev_lv_next   = avg_lv_reg;
                    prev_li_next   = avg_li_reg;
                    lc_sum_next    = '0;
                    hc_sum_next    = '0;
                    lv_sum_next    = '0;
                    hv_sum_next    = '0;
                    count_next     = '0;
                    out_valid_next = 1'b1;
                    out_duty_next  = duty_new;
                    out_dir_next   = dir_reg;
                    out_lv_next    = avg_lv_reg;
                    out_li_next    = avg_li_reg;
                    out_hv_next    = avg_hv_reg;
                    out_hi_next    = avg_hi_reg;
                    out_ov_next    = ov_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg    <= icm_pkg::SAMPLE_COUNT_RST;
            duty_step_reg       <= icm_pkg::DUTY_STEP_RST;
            voltage_band_reg    <= icm_pkg::VOLTAGE_BAND_RST;
            current_band_reg    <= icm_pkg::CURRENT_BAND_RST;
            slope_tol_reg       <= icm_pkg::SLOPE_TOL_RST;
            max_low_voltage_reg <= icm_pkg::MAX_LOW_VOLTAGE_RST;
            low_offset_reg      <= signed'(icm_pkg::LOW_OFFSET_RST);
            high_gain_reg       <= icm_pkg::HIGH_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (icm_pkg::cfg_idx_t'(cfg_index))
                icm_pkg::CFG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[icm_pkg::CNT_W-1:0];
                icm_pkg::CFG_DUTY_STEP:
                    duty_step_reg <= cfg_data[icm_pkg::STEP_W-1:0];
                icm_pkg::CFG_VOLTAGE_BAND:
                    voltage_band_reg <= cfg_data[icm_pkg::BAND_W-1:0];
                icm_pkg::CFG_CURRENT_BAND:
                    current_band_reg <= cfg_data[icm_pkg::BAND_W-1:0];
                icm_pkg::CFG_SLOPE_TOL:
                    slope_tol_reg <= cfg_data[icm_pkg::TOL_W-1:0];
                icm_pkg::CFG_MAX_LOW_VOLTAGE:
                    max_low_voltage_reg <= cfg_data[icm_pkg::VOLT_W-1:0];
                icm_pkg::CFG_LOW_OFFSET:
                    low_offset_reg <= signed'(cfg_data[icm_pkg::OFFS_W-1:0]);
                icm_pkg::CFG_HIGH_GAIN:
                    high_gain_reg <= cfg_data[icm_pkg::GAIN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= icm_pkg::ST_IDLE;
            sel_reg       <= icm_pkg::SEL_LOW_VOLT;
            lc_sum_reg    <= '0;
            hc_sum_reg    <= '0;
            lv_sum_reg    <= '0;
            hv_sum_reg    <= '0;
            count_reg     <= '0;
            prev_lv_reg   <= '0;
            prev_li_reg   <= '0;
            duty_reg      <= DUTY_RST;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            lc_sum_reg    <= lc_sum_next;
            hc_sum_reg    <= hc_sum_next;
            lv_sum_reg    <= lv_sum_next;
            hv_sum_reg    <= hv_sum_next;
            count_reg     <= count_next;
            prev_lv_reg   <= prev_lv_next;
            prev_li_reg   <= prev_li_next;
            duty_reg      <= duty_next;
            ov_reg        <= ov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg      <= dir_next;
        in_il_reg    <= in_il_next;
        in_ih_reg    <= in_ih_next;
        in_vl_reg    <= in_vl_next;
        n_reg        <= n_next;
        avg_lv_reg   <= avg_lv_next;
        avg_hv_reg   <= avg_hv_next;
        avg_li_reg   <= avg_li_next;
        avg_hi_reg   <= avg_hi_next;
        tv_reg       <= tv_next;
        lhs_reg      <= lhs_next;
        up_reg       <= up_next;
        out_duty_reg <= out_duty_next;
        out_dir_reg  <= out_dir_next;
        out_lv_reg   <= out_lv_next;
        out_li_reg   <= out_li_next;
        out_hv_reg   <= out_hv_next;
        out_hi_reg   <= out_hi_next;
        out_ov_reg   <= out_ov_next;
    end

    assign out_valid        = out_valid_reg;
    assign duty_cycle       = out_duty_reg;
    assign step_direction   = out_dir_reg;
    assign avg_low_voltage  = out_lv_reg;
    assign avg_low_current  = out_li_reg;
    assign avg_high_voltage = out_hv_reg;
    assign avg_high_current = out_hi_reg;
    assign overvoltage      = out_ov_reg;

endmodule

// ===== design/icm_chk.sv =====
// Port-level checker for the incremental conductance tracker, bound to the top level.
// Depends on icm_pkg for widths and the decision codes.
module icm_chk #(
    parameter int DUTY_BITS = 10
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic signed [icm_pkg::CUR_W-1:0]      low_current,
    input logic signed [icm_pkg::CUR_W-1:0]      high_current,
    input logic [icm_pkg::VOLT_W-1:0]            low_voltage_raw,
    input logic [icm_pkg::VOLT_W-1:0]            high_voltage_raw,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [DUTY_BITS-1:0]                  duty_cycle,
    input logic [icm_pkg::DIR_W-1:0]             step_direction,
    input logic [icm_pkg::VOLT_W-1:0]            avg_low_voltage,
    input logic signed [icm_pkg::CUR_W-1:0]      avg_low_current,
    input logic [icm_pkg::VOLT_W-1:0]            avg_high_voltage,
    input logic signed [icm_pkg::CUR_W-1:0]      avg_high_current,
    input logic                                  overvoltage,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [icm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input logic [icm_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic                 seen_reg;
    logic                 ov_seen_reg;
    logic [DUTY_BITS-1:0] last_duty_reg;
    logic                 out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            ov_seen_reg   <= 1'b0;
            last_duty_reg <= '0;
        end
        else if (out_fire)
        begin
            seen_reg      <= 1'b1;
            ov_seen_reg   <= ov_seen_reg || overvoltage;
            last_duty_reg <= duty_cycle;
        end
    end

    // hold a stalled result word: valid, duty, direction and low voltage average
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_cycle)
                                    && $stable(step_direction) && $stable(avg_low_voltage))
        else $error("result word changed while stalled");

    // drop ready after every accepted word
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in progress");

    a_hold_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg && (step_direction == icm_pkg::DIR_HOLD)
        |-> duty_cycle == last_duty_reg)
        else $error("duty moved on a hold decision");

    a_ov_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ov_seen_reg |-> overvoltage)
        else $error("overvoltage flag cleared");

endmodule

bind incremental_conductance_mppt_top icm_chk #(.DUTY_BITS(DUTY_BITS)) u_icm_chk (.*);
